// ===== design/timer_intc_uart_register_block_defines.svh =====
// Assertion macros for the timer, interrupt and UART register block.
`ifndef TIMER_INTC_UART_REGISTER_BLOCK_DEFINES_SVH
`define TIMER_INTC_UART_REGISTER_BLOCK_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define TIUR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tiur assertion failed");
// Check a property on every clock edge, reset included.
`define TIUR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tiur assertion failed");
`else
`define TIUR_ASSERT(label, clk, rst, prop)
`define TIUR_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== design/tiur_pkg.sv =====
`default_nettype none

package tiur_pkg;

  // Operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Access size codes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic [31:0] MASK_BYTE = 32'h0000_00ff;
  localparam logic [31:0] MASK_HALF = 32'h0000_ffff;

  // Register addresses
  localparam logic [31:0] ADDR_T1_INIT = 32'hb830_0000;
  localparam logic [31:0] ADDR_T1_CMP  = 32'hb830_0004;
  localparam logic [31:0] ADDR_T2_INIT = 32'hb830_0008;
  localparam logic [31:0] ADDR_T2_CMP  = 32'hb830_000c;
  localparam logic [31:0] ADDR_T1_CNT  = 32'hb830_0010;
  localparam logic [31:0] ADDR_T2_CNT  = 32'hb830_0014;
  localparam logic [31:0] ADDR_CTRL1   = 32'hb830_0018;
  localparam logic [31:0] ADDR_CTRL2   = 32'hb830_001c;
  localparam logic [31:0] ADDR_ISR     = 32'hb820_0000;
  localparam logic [31:0] ADDR_IMR     = 32'hb820_0004;
  localparam logic [31:0] ADDR_BAUD    = 32'hb850_0000;
  localparam logic [31:0] ADDR_CHAR    = 32'hb850_0004;

  // Interrupt status bit positions
  localparam int unsigned BIT_UART_EMPTY = 10;
  localparam int unsigned BIT_UART_RX    = 11;
  localparam int unsigned BIT_TIMER1     = 14;

  typedef enum logic [3:0] {
    REG_T1_INIT = 4'd0,
    REG_T1_CMP  = 4'd1,
    REG_T2_INIT = 4'd2,
    REG_T2_CMP  = 4'd3,
    REG_T1_CNT  = 4'd4,
    REG_T2_CNT  = 4'd5,
    REG_CTRL1   = 4'd6,
    REG_CTRL2   = 4'd7,
    REG_ISR     = 4'd8,
    REG_IMR     = 4'd9,
    REG_BAUD    = 4'd10,
    REG_CHAR    = 4'd11
  } reg_sel_t;

  typedef struct packed {
    logic     hit;
    reg_sel_t sel;
  } decode_t;

  // One input transaction
  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  access_size;
    logic [31:0] address;
    logic [31:0] write_data;
    logic        rx_valid;
    logic [7:0]  rx_byte;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic [31:0] read_data;
    logic        address_hit;
    logic [31:0] interrupt_status;
  } result_t;

  // Map a bus address onto a register
  function automatic decode_t decode(input logic [31:0] addr);
    decode_t d;
    d.hit = 1'b1;
    d.sel = REG_T1_INIT;
    unique case (addr)
      ADDR_T1_INIT: d.sel = REG_T1_INIT;
      ADDR_T1_CMP:  d.sel = REG_T1_CMP;
      ADDR_T2_INIT: d.sel = REG_T2_INIT;
      ADDR_T2_CMP:  d.sel = REG_T2_CMP;
      ADDR_T1_CNT:  d.sel = REG_T1_CNT;
      ADDR_T2_CNT:  d.sel = REG_T2_CNT;
      ADDR_CTRL1:   d.sel = REG_CTRL1;
      ADDR_CTRL2:   d.sel = REG_CTRL2;
      ADDR_ISR:     d.sel = REG_ISR;
      ADDR_IMR:     d.sel = REG_IMR;
      ADDR_BAUD:    d.sel = REG_BAUD;
      ADDR_CHAR:    d.sel = REG_CHAR;
      default:      d.hit = 1'b0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== design/tiur_core.sv =====
`default_nettype none

// Register file and per-transaction execution: state advances on fire.
module tiur_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire tiur_pkg::item_t  item,
  output tiur_pkg::result_t     res
);

  logic [31:0] timer1_initial, timer1_compare, timer1_count;
  logic [31:0] timer2_initial, timer2_compare, timer2_count;
  logic [31:0] timer_control_one, timer_control_two;
  logic [31:0] irq_status, irq_mask;
  logic [31:0] uart_baud, uart_character;

  logic [31:0] timer1_initial_next, timer1_compare_next, timer1_count_next;
  logic [31:0] timer2_initial_next, timer2_compare_next, timer2_count_next;
  logic [31:0] timer_control_one_next, timer_control_two_next;
  logic [31:0] irq_status_next, irq_mask_next;
  logic [31:0] uart_baud_next, uart_character_next;

  tiur_pkg::decode_t dec;
  logic [31:0]       reg_val;
  logic [31:0]       rdata;
  logic [31:0]       cnt_dec;
  logic              hit;

  assign dec     = tiur_pkg::decode(item.address);
  assign cnt_dec = timer1_count - 32'd1;

  // Select the addressed register
  always_comb begin
    unique case (dec.sel)
      tiur_pkg::REG_T1_INIT: reg_val = timer1_initial;
      tiur_pkg::REG_T1_CMP:  reg_val = timer1_compare;
      tiur_pkg::REG_T2_INIT: reg_val = timer2_initial;
      tiur_pkg::REG_T2_CMP:  reg_val = timer2_compare;
      tiur_pkg::REG_T1_CNT:  reg_val = timer1_count;
      tiur_pkg::REG_T2_CNT:  reg_val = timer2_count;
      tiur_pkg::REG_CTRL1:   reg_val = timer_control_one;
      tiur_pkg::REG_CTRL2:   reg_val = timer_control_two;
      tiur_pkg::REG_ISR:     reg_val = irq_status;
      tiur_pkg::REG_IMR:     reg_val = irq_mask;
      tiur_pkg::REG_BAUD:    reg_val = uart_baud;
      tiur_pkg::REG_CHAR:    reg_val = uart_character;
      default:               reg_val = 32'd0;
    endcase
  end

  // Execute one transaction against the register file
  always_comb begin
    timer1_initial_next    = timer1_initial;
    timer1_compare_next    = timer1_compare;
    timer1_count_next      = timer1_count;
    timer2_initial_next    = timer2_initial;
    timer2_compare_next    = timer2_compare;
    timer2_count_next      = timer2_count;
    timer_control_one_next = timer_control_one;
    timer_control_two_next = timer_control_two;
    irq_status_next        = irq_status;
    irq_mask_next          = irq_mask;
    uart_baud_next         = uart_baud;
    uart_character_next    = uart_character;
    rdata                  = 32'd0;
    hit                    = 1'b0;

    unique case (item.op)
      tiur_pkg::OP_TICK: begin
        // Advance timer one, reload on compare match
        if (cnt_dec == timer1_compare) begin
          timer1_count_next = timer1_initial;
          irq_status_next[tiur_pkg::BIT_TIMER1] = 1'b1;
        end else begin
          timer1_count_next = cnt_dec;
        end
        // Service the UART character register
        if (uart_character == 32'd0) begin
          irq_status_next[tiur_pkg::BIT_UART_EMPTY] = 1'b1;
        end else if (item.rx_valid) begin
          uart_character_next = {24'd0, item.rx_byte};
          irq_status_next[tiur_pkg::BIT_UART_RX] = 1'b1;
        end
      end
      tiur_pkg::OP_READ: begin
        if (dec.hit) begin
          hit = 1'b1;
          unique case (item.access_size)
            tiur_pkg::SIZE_BYTE: rdata = reg_val & tiur_pkg::MASK_BYTE;
            tiur_pkg::SIZE_HALF: rdata = reg_val & tiur_pkg::MASK_HALF;
            default:             rdata = reg_val;
          endcase
          // Drop the receive flag once a nonzero character is read out by a byte or word read
          if (dec.sel == tiur_pkg::REG_CHAR && item.access_size != tiur_pkg::SIZE_HALF
              && rdata != 32'd0) begin
            irq_status_next[tiur_pkg::BIT_UART_RX] = 1'b0;
          end
        end
      end
      tiur_pkg::OP_WRITE: begin
        if (dec.hit) begin
          hit = 1'b1;
          if (item.access_size == tiur_pkg::SIZE_WORD) begin
            unique case (dec.sel)
              tiur_pkg::REG_T1_INIT: begin
                timer1_initial_next = item.write_data;
                timer1_count_next   = item.write_data;
              end
              tiur_pkg::REG_T1_CMP:  timer1_compare_next    = item.write_data;
              tiur_pkg::REG_T2_INIT: timer2_initial_next    = item.write_data;
              tiur_pkg::REG_T2_CMP:  timer2_compare_next    = item.write_data;
              tiur_pkg::REG_T1_CNT:  timer1_count_next      = item.write_data;
              tiur_pkg::REG_T2_CNT:  timer2_count_next      = item.write_data;
              tiur_pkg::REG_CTRL1:   timer_control_one_next = item.write_data;
              tiur_pkg::REG_CTRL2:   timer_control_two_next = item.write_data;
              tiur_pkg::REG_ISR:     irq_status_next        = item.write_data;
              tiur_pkg::REG_IMR:     irq_mask_next          = item.write_data;
              tiur_pkg::REG_BAUD:    uart_baud_next         = item.write_data;
              tiur_pkg::REG_CHAR:    uart_character_next    = item.write_data;
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  assign res.read_data        = rdata;
  assign res.address_hit      = hit;
  assign res.interrupt_status = irq_status_next;

  // Commit the register file
  always_ff @(posedge clk) begin
    if (rst) begin
      timer1_initial    <= 32'd0;
      timer1_compare    <= 32'd0;
      timer1_count      <= 32'd0;
      timer2_initial    <= 32'd0;
      timer2_compare    <= 32'd0;
      timer2_count      <= 32'd0;
      timer_control_one <= 32'd0;
      timer_control_two <= 32'd0;
      irq_status        <= 32'd0;
      irq_mask          <= 32'd0;
      uart_baud         <= 32'd0;
      uart_character    <= 32'd0;
    end else if (fire) begin
      timer1_initial    <= timer1_initial_next;
      timer1_compare    <= timer1_compare_next;
      timer1_count      <= timer1_count_next;
      timer2_initial    <= timer2_initial_next;
      timer2_compare    <= timer2_compare_next;
      timer2_count      <= timer2_count_next;
      timer_control_one <= timer_control_one_next;
      timer_control_two <= timer_control_two_next;
      irq_status        <= irq_status_next;
      irq_mask          <= irq_mask_next;
      uart_baud         <= uart_baud_next;
      uart_character    <= uart_character_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/timer_intc_uart_register_block.sv =====
// Channel   Handshake             Payload
// input     in_valid / in_ready   op, access_size, address, write_data, rx_valid, rx_byte
// output    out_valid / out_ready read_data, address_hit, interrupt_status
//
// One transaction per clock while the result register is not held: input register then
// result register, with the register file updated as the result is loaded.
// The result register is the only stall point; while it is held, one more
// transaction waits in the input register and in_ready drops.
// Synchronous reset clears both valid flags and all twelve registers.
`default_nettype none

`include "timer_intc_uart_register_block_defines.svh"

module timer_intc_uart_register_block (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [1:0]  access_size,
  input  wire logic [31:0] address,
  input  wire logic [31:0] write_data,
  input  wire logic        rx_valid,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      read_data,
  output logic             address_hit,
  output logic [31:0]      interrupt_status
);

  tiur_pkg::item_t   item;
  tiur_pkg::result_t res;
  logic              item_valid;
  logic              fire;
  logic              tick_fire;

  // Move the held transaction on when the result register frees up
  assign fire     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || fire;

  // Flag a tick moving into the result register
  assign tick_fire = fire && item.op == tiur_pkg::OP_TICK;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= '{op: op, access_size: access_size, address: address,
                write_data: write_data, rx_valid: rx_valid, rx_byte: rx_byte};
    end
  end

  tiur_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_data        <= res.read_data;
      address_hit      <= res.address_hit;
      interrupt_status <= res.interrupt_status;
    end
  end

  `TIUR_ASSERT_ALWAYS(a_reset_empties_output, clk, rst |=> !out_valid)
  `TIUR_ASSERT(a_held_item_kept, clk, rst, item_valid && !fire |=> item_valid)
  `TIUR_ASSERT(a_tick_no_hit, clk, rst, tick_fire |=> !address_hit && read_data == '0)

endmodule

`default_nettype wire
